FILE: sv/psb_pkg.sv
// ----------------------------------------------------------------------------
// psb_pkg
// Shared types and constants of the polygon scanline span builder.
// ----------------------------------------------------------------------------
package psb_pkg;

  // Widest row index the table can ever need (256 rows)
  localparam int ROW_IDX_W = 8;

  // Sentinels of an untouched row
  localparam logic signed [10:0] EMPTY_MIN = 11'sd1000;
  localparam logic signed [10:0] EMPTY_MAX = -11'sd1000;

  // Row of a vertex is y plus this offset
  localparam logic [8:0] ROW_OFFSET = 9'd32;

  // Scanline origin: half height minus row offset
  localparam logic signed [10:0] LINE_BASE = 11'sd48;

  // Attribute value of an empty row before the sprite offset
  localparam logic signed [8:0] INVALID_BASE = 9'sd112;

  // Horizontal attribute offset
  localparam logic signed [11:0] HORZ_OFFSET = 12'sd32;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE,
    S_CLOSE,
    S_SCAN,
    S_FLUSH
  } state_t;

  // One point produced by the edge walker
  typedef struct packed {
    logic              valid;
    logic              last;
    logic signed [6:0] x;
    logic signed [5:0] y;
  } walk_pt_t;

  // Request into the span table: widen a row by x, or read it out
  typedef struct packed {
    logic                 valid;
    logic                 scan;
    logic [ROW_IDX_W-1:0] row;
    logic signed [6:0]    x;
  } span_req_t;

  // Row read back from the span table during the scan
  typedef struct packed {
    logic                 valid;
    logic [ROW_IDX_W-1:0] row;
    logic signed [10:0]   left;
    logic signed [10:0]   right;
  } span_rd_t;

endpackage

FILE: sv/psb_ram.sv
// ----------------------------------------------------------------------------
// psb_ram
// Generic single write port, single read port RAM with registered read.
// A read of the address written in the same cycle returns the old data.
// ----------------------------------------------------------------------------
module psb_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/psb_edge_walk.sv
// ----------------------------------------------------------------------------
// psb_edge_walk
// Bresenham edge walker: after a start pulse, produces one point per cycle
// from the first endpoint to the second, both included.
// ----------------------------------------------------------------------------
module psb_edge_walk (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic signed [6:0] x0,
  input  logic signed [5:0] y0,
  input  logic signed [6:0] x1,
  input  logic signed [5:0] y1,
  output psb_pkg::walk_pt_t pt
);

  logic               active;
  logic signed [6:0]  x;
  logic signed [5:0]  y;
  logic signed [6:0]  x_end;
  logic signed [5:0]  y_end;
  logic signed [10:0] dx;
  logic signed [10:0] dy;
  logic signed [10:0] err;
  logic               step_x_up;
  logic               step_y_up;

  logic [7:0]         diff_x;
  logic [6:0]         diff_y;
  logic [7:0]         mag_x;
  logic [6:0]         mag_y;
  logic signed [10:0] dx_start;
  logic signed [10:0] dy_start;
  logic signed [11:0] e2;
  logic               move_x;
  logic               move_y;
  logic               at_end;
  logic signed [10:0] err_next;

  // Set up deltas from the endpoints
  always_comb begin
    diff_x   = {x1[6], x1} - {x0[6], x0};
    diff_y   = {y1[5], y1} - {y0[5], y0};
    mag_x    = diff_x[7] ? (8'd0 - diff_x) : diff_x;
    mag_y    = diff_y[6] ? (7'd0 - diff_y) : diff_y;
    dx_start = $signed({3'b000, mag_x});
    dy_start = $signed(11'd0 - {4'b0000, mag_y});
  end

  // Decide the next step
  always_comb begin
    e2       = {err, 1'b0};
    move_x   = e2 >= $signed({dy[10], dy});
    move_y   = e2 <= $signed({dx[10], dx});
    at_end   = (x == x_end) && (y == y_end);
    err_next = err + (move_x ? dy : 11'sd0) + (move_y ? dx : 11'sd0);
  end

  // Advance the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (start) begin
      active <= 1'b1;
    end else if (active && at_end) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x         <= x0;
      y         <= y0;
      x_end     <= x1;
      y_end     <= y1;
      dx        <= dx_start;
      dy        <= dy_start;
      err       <= dx_start + dy_start;
      step_x_up <= x0 < x1;
      step_y_up <= y0 < y1;
    end else if (active && !at_end) begin
      err <= err_next;
      if (move_x) begin
        x <= step_x_up ? (x + 7'sd1) : (x - 7'sd1);
      end
      if (move_y) begin
        y <= step_y_up ? (y + 6'sd1) : (y - 6'sd1);
      end
    end
  end

  always_comb begin
    pt.valid = active;
    pt.last  = active && at_end;
    pt.x     = x;
    pt.y     = y;
  end

  // Walk never overruns its end point
  assert property (@(posedge clk) disable iff (rst) pt.last |=> !active || $past(start))
    else $error("edge walker kept running after its end point");

  // Restart only while idle or on the last point of an edge
  assert property (@(posedge clk) disable iff (rst) start |-> !active || at_end)
    else $error("edge walker restarted in mid edge");

endmodule

FILE: sv/psb_span_table.sv
// ----------------------------------------------------------------------------
// psb_span_table
// Span table: least and greatest x per row, held in one RAM with a
// read-modify-write pipeline and forwarding of the previous write.
// Per-row valid bits stand in for the sentinel reset values.
// ----------------------------------------------------------------------------
module psb_span_table #(
  parameter int ROWS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  psb_pkg::span_req_t req,
  input  logic               clear_all,
  output psb_pkg::span_rd_t  rd
);

  localparam int RW = $clog2(ROWS);

  logic [21:0]        ram_rdata;
  logic               wr_en;
  logic [21:0]        wr_data;

  logic               s2_valid;
  logic               s2_scan;
  logic [RW-1:0]      s2_row;
  logic signed [6:0]  s2_x;

  logic               fwd_valid;
  logic [RW-1:0]      fwd_row;
  logic [21:0]        fwd_data;

  logic [ROWS-1:0]    row_valid;

  logic               fwd_hit;
  logic signed [10:0] cur_min;
  logic signed [10:0] cur_max;
  logic signed [10:0] x_ext;
  logic signed [10:0] new_min;
  logic signed [10:0] new_max;

  psb_ram #(
    .WIDTH(22),
    .DEPTH(ROWS)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(s2_row),
    .wdata(wr_data),
    .raddr(req.row[RW-1:0]),
    .rdata(ram_rdata)
  );

  // Register the request alongside the RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_scan <= req.scan;
    s2_row  <= req.row[RW-1:0];
    s2_x    <= req.x;
  end

  // Merge: forwarded write, else RAM data, else sentinels
  always_comb begin
    fwd_hit = fwd_valid && (fwd_row == s2_row);
    if (fwd_hit) begin
      cur_min = fwd_data[21:11];
      cur_max = fwd_data[10:0];
    end else if (row_valid[s2_row]) begin
      cur_min = ram_rdata[21:11];
      cur_max = ram_rdata[10:0];
    end else begin
      cur_min = psb_pkg::EMPTY_MIN;
      cur_max = psb_pkg::EMPTY_MAX;
    end
    x_ext   = {{4{s2_x[6]}}, s2_x};
    new_min = (x_ext < cur_min) ? x_ext : cur_min;
    new_max = (x_ext > cur_max) ? x_ext : cur_max;
    wr_en   = s2_valid && !s2_scan;
    wr_data = {new_min, new_max};
  end

  // Hold the last write for the read that overlapped it
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_row  <= s2_row;
      fwd_data <= wr_data;
    end
  end

  // Mark written rows, drop all at the end of a polygon
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[s2_row] <= 1'b1;
    end
  end

  always_comb begin
    rd.valid = s2_valid && s2_scan;
    rd.row   = psb_pkg::ROW_IDX_W'(s2_row);
    rd.left  = cur_min;
    rd.right = cur_max;
  end

  // Clearing never coincides with a write
  assert property (@(posedge clk) disable iff (rst) clear_all |-> !wr_en)
    else $error("span table cleared while a row was written");

  // After a clear every row reads as empty
  assert property (@(posedge clk) disable iff (rst) clear_all |=> row_valid == '0)
    else $error("span table rows survived a clear");

  // A forwarded row was written in the cycle before
  assert property (@(posedge clk) disable iff (rst) fwd_hit |-> $past(wr_en))
    else $error("span table forwarded a stale write");

endmodule

FILE: sv/polygon_scanline_span_builder.sv
// ----------------------------------------------------------------------------
// polygon_scanline_span_builder
// Builds per-row spans of a polygon from its vertices and reports them.
// ----------------------------------------------------------------------------
// A vertex is taken when start is high and busy is low. A vertex that does
// not close the polygon starts the edge from the previous vertex, which has
// N = max(|dx|, |dy|) + 1 points (the first vertex starts no edge); the edge
// walker marks one point per cycle into the span RAM, and busy stays high
// while the edge is walked. A closing vertex adds the closing edge (a single
// point for a single-vertex polygon), a readout of ROWS rows, one row per
// cycle, and a clear of the table. Its results pass the table's request
// register and the result register and come out one per cycle, the last in
// the first cycle with busy low again; each is valid for exactly one cycle
// under result_valid and must be taken as it appears, since the block cannot
// be stalled. final_row marks the last row. Right after the readout the
// table is empty again and the next vertex starts a new polygon.
// sprite_top is written through the cfg channel, which is always ready;
// write it only while the block is idle.
// ----------------------------------------------------------------------------
module polygon_scanline_span_builder #(
  parameter int ROWS = 64
) (
  input  logic                      clk,
  input  logic                      rst,

  input  logic                      start,
  output logic                      busy,
  input  logic signed [6:0]         vertex_x,
  input  logic signed [5:0]         vertex_y,
  input  logic                      closing_vertex,

  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic signed [7:0]         cfg_data,

  output logic                      result_valid,
  output logic [$clog2(ROWS)-1:0]   row_index,
  output logic signed [8:0]         screen_line,
  output logic signed [10:0]        left_edge,
  output logic signed [10:0]        right_edge,
  output logic                      has_span,
  output logic signed [8:0]         attr_vertical,
  output logic signed [11:0]        attr_horizontal,
  output logic                      final_row
);

  localparam int         RW        = $clog2(ROWS);
  localparam logic [8:0] ROWS_L    = 9'(ROWS);
  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [psb_pkg::ROW_IDX_W-1:0] LAST_ROW_IDX =
    psb_pkg::ROW_IDX_W'(ROWS - 1);

  psb_pkg::state_t    state;
  psb_pkg::state_t    state_next;

  logic signed [7:0]  sprite_top;
  logic signed [6:0]  origin_x;
  logic signed [5:0]  origin_y;
  logic signed [6:0]  previous_x;
  logic signed [5:0]  previous_y;
  logic               have_previous;
  logic               closing;
  logic [RW-1:0]      scan_row;

  logic               accept;
  logic               walk_start;
  logic signed [6:0]  walk_x0;
  logic signed [5:0]  walk_y0;
  logic signed [6:0]  walk_x1;
  logic signed [5:0]  walk_y1;
  logic               clear_all;
  logic               scan_last;

  psb_pkg::walk_pt_t  pt;
  psb_pkg::span_req_t req;
  psb_pkg::span_rd_t  rd;

  logic [8:0]         pt_row;

  logic [10:0]        row_ext;
  logic [10:0]        line_sum;
  logic [11:0]        length;
  logic               span_pos;
  logic [12:0]        vert_sum;
  logic [8:0]         vert_empty;
  logic [11:0]        horz_sum;

  assign accept    = start && !busy;
  assign busy      = state != psb_pkg::S_IDLE;
  assign cfg_ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_top <= '0;
    end else if (cfg_valid && cfg_ready) begin
      sprite_top <= cfg_data;
    end
  end

  // Vertex chain
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= '0;
      origin_y      <= '0;
      previous_x    <= '0;
      previous_y    <= '0;
      have_previous <= 1'b0;
      closing       <= 1'b0;
    end else if (accept) begin
      if (!have_previous) begin
        origin_x <= vertex_x;
        origin_y <= vertex_y;
      end
      previous_x    <= vertex_x;
      previous_y    <= vertex_y;
      have_previous <= 1'b1;
      closing       <= closing_vertex;
    end else if (state == psb_pkg::S_FLUSH) begin
      have_previous <= 1'b0;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Readout row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row <= '0;
    end else if (state == psb_pkg::S_SCAN) begin
      scan_row <= scan_last ? '0 : (scan_row + 1'b1);
    end
  end

  assign scan_last = scan_row == LAST_ROW;

  // Sequence the edges, the readout and the clear
  always_comb begin
    state_next = state;
    walk_start = 1'b0;
    walk_x0    = previous_x;
    walk_y0    = previous_y;
    walk_x1    = origin_x;
    walk_y1    = origin_y;
    clear_all  = 1'b0;
    unique case (state)
      psb_pkg::S_IDLE: begin
        walk_x0 = have_previous ? previous_x : vertex_x;
        walk_y0 = have_previous ? previous_y : vertex_y;
        walk_x1 = vertex_x;
        walk_y1 = vertex_y;
        if (accept) begin
          if (have_previous) begin
            walk_start = 1'b1;
            state_next = psb_pkg::S_EDGE;
          end else if (closing_vertex) begin
            walk_start = 1'b1;
            state_next = psb_pkg::S_CLOSE;
          end
        end
      end
      psb_pkg::S_EDGE: begin
        if (pt.last) begin
          if (closing) begin
            walk_start = 1'b1;
            state_next = psb_pkg::S_CLOSE;
          end else begin
            state_next = psb_pkg::S_IDLE;
          end
        end
      end
      psb_pkg::S_CLOSE: begin
        if (pt.last) begin
          state_next = psb_pkg::S_SCAN;
        end
      end
      psb_pkg::S_SCAN: begin
        if (scan_last) begin
          state_next = psb_pkg::S_FLUSH;
        end
      end
      psb_pkg::S_FLUSH: begin
        clear_all  = 1'b1;
        state_next = psb_pkg::S_IDLE;
      end
      default: begin
        state_next = psb_pkg::S_IDLE;
      end
    endcase
  end

  psb_edge_walk u_walk (
    .clk  (clk),
    .rst  (rst),
    .start(walk_start),
    .x0   (walk_x0),
    .y0   (walk_y0),
    .x1   (walk_x1),
    .y1   (walk_y1),
    .pt   (pt)
  );

  // Map a point to its row; drop rows past the table
  always_comb begin
    pt_row = {3'b000, ~pt.y[5], pt.y[4:0]};
    if (state == psb_pkg::S_SCAN) begin
      req.valid = 1'b1;
      req.scan  = 1'b1;
      req.row   = psb_pkg::ROW_IDX_W'(scan_row);
      req.x     = '0;
    end else begin
      req.valid = pt.valid && (pt_row < ROWS_L);
      req.scan  = 1'b0;
      req.row   = pt_row[psb_pkg::ROW_IDX_W-1:0];
      req.x     = pt.x;
    end
  end

  psb_span_table #(
    .ROWS(ROWS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .clear_all(clear_all),
    .rd       (rd)
  );

  // Format a row result
  always_comb begin
    row_ext    = {3'b000, rd.row};
    line_sum   = psb_pkg::LINE_BASE + {{3{sprite_top[7]}}, sprite_top} + row_ext;
    length     = {rd.right[10], rd.right} - {rd.left[10], rd.left};
    span_pos   = $signed(length) > 12'sd0;
    vert_sum   = {5'b00000, rd.row} + 13'd1 - {length[11], length};
    vert_empty = psb_pkg::INVALID_BASE - {sprite_top[7], sprite_top};
    horz_sum   = {rd.left[10], rd.left} + psb_pkg::HORZ_OFFSET;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= rd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.valid) begin
      row_index       <= rd.row[RW-1:0];
      screen_line     <= line_sum[8:0];
      left_edge       <= rd.left;
      right_edge      <= rd.right;
      has_span        <= span_pos;
      attr_vertical   <= span_pos ? vert_sum[8:0] : vert_empty;
      attr_horizontal <= horz_sum;
      final_row       <= rd.row == LAST_ROW_IDX;
    end
  end

  // Results come only from a readout, through the table's request register and the result register
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state, 2) == psb_pkg::S_SCAN)
    else $error("result without a table readout");

  // Points are only walked while a transaction is in progress
  assert property (@(posedge clk) disable iff (rst) pt.valid |-> busy)
    else $error("edge walk outside a transaction");

  // The last row is followed by the table clear
  assert property (@(posedge clk) disable iff (rst)
    (state == psb_pkg::S_SCAN) && scan_last |=> clear_all)
    else $error("span table not cleared after readout");

endmodule
